[rtl/core/rnpi_pkg.sv]
// Shared types and constants for the RGB565 nearest palette index block.
// Holds the channel, candidate and register index definitions.
// No dependencies.
package rnpi_pkg;

  localparam int unsigned ChanW = 8;
  localparam int unsigned DistW = 18;
  localparam int unsigned IdxW = 3;
  localparam int unsigned ColorW = 24;
  localparam int unsigned Lanes = 8;
  localparam int unsigned PipeDepth = 6;

  // Truncating c*255/31 and c*255/63 as a multiply by a scaled reciprocal.
  localparam logic [26:0] Widen5Mul = 27'd2156535;
  localparam int unsigned Widen5Shift = 18;
  localparam logic [28:0] Widen6Mul = 29'd4244475;
  localparam int unsigned Widen6Shift = 20;

  localparam logic [3:0] CFG_IDX_COLORS = 4'd0;
  localparam logic [3:0] CFG_IDX_PALETTE0 = 4'd1;

  localparam logic [IdxW-1:0] ColorsReset = 3'd2;
  localparam logic [ColorW-1:0] PaletteReset = 24'h000000;
  localparam logic [ColorW-1:0] Palette1Reset = 24'hFFFFFF;

  typedef struct packed {
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
  } rnpi_rgb_t;

  typedef struct packed {
    logic in_use;
    logic [IdxW-1:0] idx;
    logic [DistW-1:0] sq_dist;
  } rnpi_cand_t;

endpackage

[rtl/core/rgb565_nearest_palette_index.sv]
// RGB565 nearest palette index: one pixel per cycle, never busy.
// The pipeline has six register stages: widen, square, sum and three minimum tree
// levels, ending in done_o. Throughput is one transaction per cycle; the receiver
// cannot stall. Reset clears the pipeline valids and loads the palette registers
// with their reset values; no clearing pass is needed.
module rgb565_nearest_palette_index import rnpi_pkg::*; #(
  parameter int unsigned MAX_PALETTE = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [15:0]       pixel_i,
  output logic              done_o,
  output logic [IdxW-1:0]   color_index_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [3:0]        cfg_index_i,
  input  logic [ColorW-1:0] cfg_data_i
);

  logic                   cfg_we;
  logic [IdxW-1:0]        colors_q;
  logic [IdxW-1:0]        count_eff;
  logic [ColorW-1:0]      entry_q [MAX_PALETTE];
  logic [DistW-1:0]       entry_dist [MAX_PALETTE];
  logic                   accept;
  logic                   s1_valid;
  rnpi_rgb_t              s1_pix;
  logic                   s2_valid_q;
  logic                   s3_valid_q;
  rnpi_cand_t [Lanes-1:0] cand;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colors_q <= ColorsReset;
    end else if (cfg_we && (cfg_index_i == CFG_IDX_COLORS)) begin
      colors_q <= cfg_data_i[IdxW-1:0];
    end
  end

  for (genvar e = 0; e < MAX_PALETTE; e++) begin : g_entry
    localparam logic [ColorW-1:0] EntryReset = (e == 1) ? Palette1Reset : PaletteReset;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        entry_q[e] <= EntryReset;
      end else if (cfg_we && (cfg_index_i == CFG_IDX_PALETTE0 + 4'(e))) begin
        entry_q[e] <= cfg_data_i;
      end
    end

    rnpi_dist u_dist (
      .clk_i   (clk_i),
      .pix_i   (s1_pix),
      .entry_i (entry_q[e]),
      .dist_o  (entry_dist[e])
    );
  end

  assign count_eff = (colors_q > IdxW'(MAX_PALETTE)) ? IdxW'(MAX_PALETTE) : colors_q;

  rnpi_widen u_widen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .pixel_i (pixel_i),
    .valid_o (s1_valid),
    .pix_o   (s1_pix)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid;
      s3_valid_q <= s2_valid_q;
    end
  end

  for (genvar i = 0; i < Lanes; i++) begin : g_lane
    if (i < MAX_PALETTE) begin : g_used
      assign cand[i].in_use  = (IdxW'(i) < count_eff);
      assign cand[i].idx     = IdxW'(i);
      assign cand[i].sq_dist = entry_dist[i];
    end else begin : g_pad
      assign cand[i].in_use  = 1'b0;
      assign cand[i].idx     = IdxW'(i);
      assign cand[i].sq_dist = '0;
    end
  end

  rnpi_min u_min (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_valid_q),
    .cand_i  (cand),
    .valid_o (done_o),
    .index_o (color_index_o)
  );

`ifndef SYNTHESIS
  a_done_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, PipeDepth))
    else $error("Result strobe without a matching accepted transaction.");

  a_accept_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##6 done_o)
    else $error("Accepted transaction produced no result.");

  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((color_index_o < count_eff) || (color_index_o == '0)))
    else $error("Result index outside the entries in use.");
`endif

endmodule

[rtl/core/rnpi_widen.sv]
// First pipeline stage: splits an RGB565 pixel and widens each channel to 8 bits.
// Depends on rnpi_pkg.
module rnpi_widen import rnpi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [15:0] pixel_i,
  output logic        valid_o,
  output rnpi_rgb_t   pix_o
);

  logic [26:0] r_prod;
  logic [28:0] g_prod;
  logic [26:0] b_prod;
  rnpi_rgb_t   pix_d;
  rnpi_rgb_t   pix_q;
  logic        valid_q;

  assign r_prod = 27'(pixel_i[15:11]) * Widen5Mul;
  assign g_prod = 29'(pixel_i[10:5]) * Widen6Mul;
  assign b_prod = 27'(pixel_i[4:0]) * Widen5Mul;

  assign pix_d.r = r_prod[Widen5Shift +: ChanW];
  assign pix_d.g = g_prod[Widen6Shift +: ChanW];
  assign pix_d.b = b_prod[Widen5Shift +: ChanW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
  end

  assign valid_o = valid_q;
  assign pix_o   = pix_q;

endmodule

[rtl/core/rnpi_dist.sv]
// Squared distance from the widened pixel to one palette entry over two stages.
// Depends on rnpi_pkg.
module rnpi_dist import rnpi_pkg::*; (
  input  logic              clk_i,
  input  rnpi_rgb_t         pix_i,
  input  logic [ColorW-1:0] entry_i,
  output logic [DistW-1:0]  dist_o
);

  logic [ChanW-1:0]   dr;
  logic [ChanW-1:0]   dg;
  logic [ChanW-1:0]   db;
  logic [2*ChanW-1:0] sq_r_q;
  logic [2*ChanW-1:0] sq_g_q;
  logic [2*ChanW-1:0] sq_b_q;
  logic [DistW-1:0]   dist_d;
  logic [DistW-1:0]   dist_q;

  always_comb begin
    dr = (pix_i.r > entry_i[23:16]) ? pix_i.r - entry_i[23:16] : entry_i[23:16] - pix_i.r;
    dg = (pix_i.g > entry_i[15:8]) ? pix_i.g - entry_i[15:8] : entry_i[15:8] - pix_i.g;
    db = (pix_i.b > entry_i[7:0]) ? pix_i.b - entry_i[7:0] : entry_i[7:0] - pix_i.b;
  end

  assign dist_d = DistW'(sq_r_q) + DistW'(sq_g_q) + DistW'(sq_b_q);

  always_ff @(posedge clk_i) begin
    sq_r_q <= (2*ChanW)'(dr) * (2*ChanW)'(dr);
    sq_g_q <= (2*ChanW)'(dg) * (2*ChanW)'(dg);
    sq_b_q <= (2*ChanW)'(db) * (2*ChanW)'(db);
    dist_q <= dist_d;
  end

  assign dist_o = dist_q;

endmodule

[rtl/core/rnpi_min.sv]
// Registered three-level minimum tree over eight distance candidates.
// Depends on rnpi_pkg; the lower index wins on equal distances.
module rnpi_min import rnpi_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  rnpi_cand_t [Lanes-1:0] cand_i,
  output logic                   valid_o,
  output logic [IdxW-1:0]        index_o
);

  function automatic rnpi_cand_t pick(input rnpi_cand_t a, input rnpi_cand_t b);
    rnpi_cand_t res;
    res = a;
    if (b.in_use && (!a.in_use || (b.sq_dist < a.sq_dist))) begin
      res = b;
    end
    return res;
  endfunction

  rnpi_cand_t l1_q [4];
  rnpi_cand_t l2_q [2];
  rnpi_cand_t l3_q;
  logic       v1_q;
  logic       v2_q;
  logic       v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      l1_q[k] <= pick(cand_i[2*k], cand_i[2*k+1]);
    end
    for (int k = 0; k < 2; k++) begin
      l2_q[k] <= pick(l1_q[2*k], l1_q[2*k+1]);
    end
    l3_q <= pick(l2_q[0], l2_q[1]);
  end

  assign valid_o = v3_q;
  assign index_o = l3_q.in_use ? l3_q.idx : '0;

endmodule

[sim/rgb565_nearest_palette_index_tb.sv]
`timescale 1ns / 100ps
// Testbench for rgb565_nearest_palette_index: streams RGB565 pixels, some with random gaps, across
// palette reconfigurations and checks each color index against a behavioral nearest-color search.
// Depends on rnpi_pkg and the RTL of the block.
module rgb565_nearest_palette_index_tb;
  import rnpi_pkg::*;

  localparam int unsigned MaxPalette = 7;
  localparam int unsigned PaletteRegs = 7;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandomPhases = 8;
  localparam int unsigned PixelsPerPhase = 125;

  class nearest_index_tracker;
    logic [IdxW-1:0] colors_in_use;
    logic [ColorW-1:0] palette [PaletteRegs];
    logic [IdxW-1:0] expected_index_q [$];
    int unsigned fails;

    function new();
      colors_in_use = ColorsReset;
      foreach (palette[i]) palette[i] = PaletteReset;
      palette[1] = Palette1Reset;
      fails = 0;
    endfunction

    function void write_reg(logic [3:0] idx, logic [ColorW-1:0] data);
      if (idx == CFG_IDX_COLORS) begin
        colors_in_use = data[IdxW-1:0];
      end else if (idx >= CFG_IDX_PALETTE0 && idx < CFG_IDX_PALETTE0 + PaletteRegs) begin
        palette[idx - CFG_IDX_PALETTE0] = data;
      end
    endfunction

    function int unsigned widen(int unsigned c, int unsigned full);
      return (c * 255) / full;
    endfunction

    function void note_pixel(logic [15:0] px);
      int unsigned chan [3];
      int unsigned count;
      int unsigned sq_dist;
      int unsigned best_dist;
      int unsigned d;
      logic [IdxW-1:0] best;
      chan[0] = widen(px[15:11], 31);
      chan[1] = widen(px[10:5], 63);
      chan[2] = widen(px[4:0], 31);
      count = (colors_in_use > MaxPalette) ? MaxPalette : colors_in_use;
      best = '0;
      best_dist = 0;
      for (int i = 0; i < count; i++) begin
        sq_dist = 0;
        for (int k = 0; k < 3; k++) begin
          d = palette[i][8*(2-k) +: 8];
          d = (chan[k] > d) ? chan[k] - d : d - chan[k];
          sq_dist += d * d;
        end
        // Strict compare keeps the lowest index among equal distances.
        if (i == 0 || sq_dist < best_dist) begin
          best_dist = sq_dist;
          best = IdxW'(i);
        end
      end
      expected_index_q.push_back(best);
    endfunction

    function void check_index(logic [IdxW-1:0] actual);
      logic [IdxW-1:0] expected;
      if (expected_index_q.size() == 0) begin
        $error("color_index: expected none, actual %0d", actual);
        fails++;
        return;
      end
      expected = expected_index_q.pop_front();
      if (actual !== expected) begin
        $error("color_index: expected %0d, actual %0d", expected, actual);
        fails++;
      end
    endfunction

    function int unsigned pending();
      return expected_index_q.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [15:0]       pixel_i;
  logic              done_o;
  logic [IdxW-1:0]   color_index_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [3:0]        cfg_index_i;
  logic [ColorW-1:0] cfg_data_i;

  nearest_index_tracker board = new();
  int unsigned cycle_count = 0;

  rgb565_nearest_palette_index #(
    .MAX_PALETTE(MaxPalette)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .pixel_i       (pixel_i),
    .done_o        (done_o),
    .color_index_o (color_index_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) board.write_reg(cfg_index_i, cfg_data_i);
      if (done_o) board.check_index(color_index_o);
      if (start && !busy) board.note_pixel(pixel_i);
    end
  end

  // Leaves start high so that back-to-back pixels need no extra edge.
  task automatic send_pixel(input logic [15:0] px, input int unsigned gap);
    repeat (gap) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    pixel_i <= px;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [3:0] idx, input logic [ColorW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (PipeDepth + 2) @(posedge clk_i);
  endtask

  task automatic load_palette(input int unsigned phase);
    logic [ColorW-1:0] entry;
    logic [ColorW-1:0] prev;
    logic [IdxW-1:0] count;
    prev = ColorW'($urandom());
    for (int i = 0; i < PaletteRegs; i++) begin
      case ($urandom_range(0, 3))
        0: entry = 24'h000000;
        1: entry = 24'hFFFFFF;
        2: entry = prev;
        default: entry = ColorW'($urandom());
      endcase
      write_cfg(CFG_IDX_PALETTE0 + 4'(i), entry);
      prev = entry;
    end
    case (phase)
      0: count = 3'd7;
      1: count = 3'd0;
      2: count = 3'd1;
      default: count = IdxW'($urandom_range(0, 7));
    endcase
    write_cfg(CFG_IDX_COLORS, {21'($urandom()), count});
    write_cfg(4'($urandom_range(8, 15)), ColorW'($urandom()));
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] pin_channel(logic [15:0] px, logic [15:0] mask);
    case ($urandom_range(0, 2))
      0: return px & ~mask;
      1: return px | mask;
      default: return px;
    endcase
  endfunction

  initial begin
    logic [15:0] corner_px [6];
    logic [15:0] px;
    int unsigned gap;
    corner_px = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F, 16'h8410};
    rst_ni = 1'b0;
    start = 1'b0;
    pixel_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_px[i]) send_pixel(corner_px[i], 0);
    start <= 1'b0;
    drain();

    // Entries 1 to 4 sit at equal distance from black, so black must map to entry 1.
    write_cfg(CFG_IDX_COLORS, 24'hFFFFFF);
    write_cfg(CFG_IDX_PALETTE0, 24'hFFFFFF);
    write_cfg(CFG_IDX_PALETTE0 + 4'd1, 24'h0A0000);
    write_cfg(CFG_IDX_PALETTE0 + 4'd2, 24'h000A00);
    write_cfg(CFG_IDX_PALETTE0 + 4'd3, 24'h00000A);
    write_cfg(CFG_IDX_PALETTE0 + 4'd4, 24'h0A0000);
    write_cfg(CFG_IDX_PALETTE0 + 4'd5, 24'hF80000);
    write_cfg(CFG_IDX_PALETTE0 + 4'd6, 24'h00FF00);
    cfg_valid_i <= 1'b0;
    foreach (corner_px[i]) send_pixel(corner_px[i], i % 2);
    start <= 1'b0;
    drain();

    write_cfg(CFG_IDX_COLORS, 24'h000008);
    write_cfg(4'hF, 24'h123456);
    cfg_valid_i <= 1'b0;
    for (int i = 0; i < 3; i++) send_pixel(corner_px[i], 0);
    start <= 1'b0;
    drain();

    for (int phase = 0; phase < RandomPhases; phase++) begin
      load_palette(phase);
      repeat (PixelsPerPhase) begin
        px = 16'($urandom());
        if ($urandom_range(0, 3) == 0) begin
          px = pin_channel(px, 16'hF800);
          px = pin_channel(px, 16'h07E0);
          px = pin_channel(px, 16'h001F);
        end
        gap = 0;
        if (phase < RandomPhases - 2 && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
        send_pixel(px, gap);
      end
      start <= 1'b0;
      drain();
    end

    if (board.fails == 0 && board.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
